FILE: rtl/core/bcdc_pkg.sv
// Package for the two-digit seven-segment counter with temperature display.
// Types, register map, arithmetic constants and the segment decoder.
// No dependencies.
`default_nettype none

package bcdc_pkg;

    // Converter sample width
    localparam int ADC_BITS = 10;

    // Configuration field widths
    localparam int LIMIT_W  = 16;
    localparam int GAIN_W   = 10;
    localparam int OFFSET_W = 10;

    // Scaling: sample * gain, then divide by 1024 (shift)
    localparam int TEMP_DIVISOR = 1024;
    localparam int TEMP_SHIFT   = $clog2(TEMP_DIVISOR);
    localparam int PROD_W       = ADC_BITS + GAIN_W;

    // Temperature is kept to 8 bits; tens digit of 0..255 is 0..25
    localparam int TEMP_W  = 8;
    localparam int TENS_W  = 5;
    localparam int DIGIT_W = 4;

    // Divide by ten through reciprocal: x * 205 >> 11, exact for 0..255
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;
    localparam int DIV10_W     = TEMP_W + 8;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    // Register reset values
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd1024;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 10'd420;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd278;

    // APB
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Segment byte marker for the tens digit
    localparam logic [7:0] TENS_SELECT = 8'b0000_1000;

    // Register indexes
    typedef enum logic [1:0] {
        REG_PRESCALE_LIMIT = 2'd0,
        REG_TEMP_GAIN      = 2'd1,
        REG_TEMP_OFFSET    = 2'd2
    } reg_index_t;

    // Configuration passed to the datapath
    typedef struct packed {
        logic [LIMIT_W-1:0]  prescale_limit;
        logic [GAIN_W-1:0]   temp_gain;
        logic [OFFSET_W-1:0] temp_offset;
    } cfg_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic accept;     // take the item, start multiply, step counter in counter mode
        logic scale;      // shift and subtract offset
        logic divide;     // tens digit by reciprocal
        logic load_out;   // form the segment byte
    } cmd_t;

    // Seven-segment pattern; anything above nine shows zero
    function automatic logic [7:0] digit_pattern(input logic [TENS_W-1:0] d);
        logic [7:0] p;
        unique case (d)
            5'd0:    p = 8'b1111_0011;
            5'd1:    p = 8'b0110_0000;
            5'd2:    p = 8'b1011_0101;
            5'd3:    p = 8'b1111_0100;
            5'd4:    p = 8'b0110_0110;
            5'd5:    p = 8'b1101_0110;
            5'd6:    p = 8'b1101_0111;
            5'd7:    p = 8'b0111_0000;
            5'd8:    p = 8'b1111_0111;
            5'd9:    p = 8'b1111_0110;
            default: p = 8'b1111_0011;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bcdc_regs.sv
// APB configuration registers: prescale limit, temperature gain and offset.
// Depends on bcdc_pkg.
`default_nettype none

module bcdc_regs
    import bcdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [LIMIT_W-1:0]  limit_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [OFFSET_W-1:0] offset_reg;
    reg_index_t          index;
    logic                wr_en;

    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes; unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_PRESCALE_LIMIT: limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_TEMP_GAIN:      gain_reg   <= pwdata[GAIN_W-1:0];
                REG_TEMP_OFFSET:    offset_reg <= pwdata[OFFSET_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (index)
            REG_PRESCALE_LIMIT: prdata = APB_DATA_W'(limit_reg);
            REG_TEMP_GAIN:      prdata = APB_DATA_W'(gain_reg);
            REG_TEMP_OFFSET:    prdata = APB_DATA_W'(offset_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.prescale_limit = limit_reg;
    assign cfg.temp_gain      = gain_reg;
    assign cfg.temp_offset    = offset_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bcdc_ctrl.sv
// Controller: sequences accept, scale, divide and output load for each item.
// Owns the input stall and the output valid. Depends on bcdc_pkg.
`default_nettype none

module bcdc_ctrl
    import bcdc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    output cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCALE = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_FMT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.scale    = 1'b0;
        cmd.divide   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.divide = 1'b1;
                state_next = ST_FMT;
            end
            ST_FMT:
            begin
                // wait until the output register can take the item
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bcdc_dp.sv
// Datapath: prescaler, decimal counter, temperature scaling, digit split and
// segment decode. Driven by bcdc_ctrl commands. Depends on bcdc_pkg.
`default_nettype none

module bcdc_dp
    import bcdc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    input  wire cfg_t                cfg,
    input  wire logic                show_temperature,
    input  wire logic [ADC_BITS-1:0] adc_sample,
    output logic      [7:0]          segment_byte
);

    // Control state
    logic [LIMIT_W-1:0] prescale_reg, prescale_next;
    logic [DIGIT_W-1:0] units_reg, units_next;
    logic [DIGIT_W-1:0] tens_cnt_reg, tens_cnt_next;
    logic               units_turn_reg;

    // Payload pipeline
    logic               mode_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TEMP_W-1:0]  temp_reg;
    logic [TENS_W-1:0]  tens_reg;
    logic [7:0]         seg_reg;

    logic [PROD_W-1:0]  prod_next;
    logic [TEMP_W-1:0]  temp_next;
    logic [DIV10_W-1:0] div_prod;
    logic [TEMP_W-1:0]  units_wide;
    logic [TENS_W-1:0]  show_units;
    logic [TENS_W-1:0]  show_tens;
    logic [7:0]         seg_next;

    // Counter step, counter mode only
    always_comb
    begin
        prescale_next = prescale_reg;
        units_next    = units_reg;
        tens_cnt_next = tens_cnt_reg;
        if (prescale_reg == cfg.prescale_limit)
        begin
            prescale_next = '0;
            if (units_reg >= DIGIT_MAX)
            begin
                units_next = '0;
                if (tens_cnt_reg >= DIGIT_MAX)
                    tens_cnt_next = '0;
                else
                    tens_cnt_next = tens_cnt_reg + 1'b1;
            end
            else
            begin
                units_next = units_reg + 1'b1;
            end
        end
        else
        begin
            prescale_next = prescale_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg   <= '0;
            units_reg      <= '0;
            tens_cnt_reg   <= '0;
            units_turn_reg <= 1'b1;
        end
        else
        begin
            if (cmd.accept && !show_temperature)
            begin
                prescale_reg <= prescale_next;
                units_reg    <= units_next;
                tens_cnt_reg <= tens_cnt_next;
            end
            if (cmd.load_out)
                units_turn_reg <= !units_turn_reg;
        end
    end

    // Full-width product of sample and gain
    assign prod_next = PROD_W'(adc_sample) * PROD_W'(cfg.temp_gain);

    // Divide by 1024, subtract offset, keep low 8 bits
    assign temp_next = prod_reg[TEMP_SHIFT +: TEMP_W] - cfg.temp_offset[TEMP_W-1:0];

    // Tens by reciprocal multiply
    assign div_prod = DIV10_W'(temp_reg) * DIV10_W'(DIV10_MUL);

    // Units as remainder
    assign units_wide = temp_reg - TEMP_W'(tens_reg) * TEMP_W'(4'd10);

    // Digit selection and decode
    always_comb
    begin
        if (mode_reg)
        begin
            show_units = units_wide[TENS_W-1:0];
            show_tens  = tens_reg;
        end
        else
        begin
            show_units = TENS_W'(units_reg);
            show_tens  = TENS_W'(tens_cnt_reg);
        end
        if (units_turn_reg)
            seg_next = digit_pattern(show_units);
        else
            seg_next = digit_pattern(show_tens) | TENS_SELECT;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= show_temperature;
            prod_reg <= prod_next;
        end
        if (cmd.scale)
            temp_reg <= temp_next;
        if (cmd.divide)
            tens_reg <= div_prod[DIV10_SHIFT +: TENS_W];
        if (cmd.load_out)
            seg_reg <= seg_next;
    end

    assign segment_byte = seg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bcd_counter_temp_7seg_mux_unit.sv
// Two-digit seven-segment counter with temperature display.
// Each item is multiplied at acceptance, then scaled, divided by ten and
// formatted; format waits while the previous result is held.
// The controller's four-state sequence stalls the input until the previous item is formatted.
// Reset (rst_n, async, active low): counter and prescaler zero, units digit
// first, registers at prescale_limit 1024, temp_gain 420, temp_offset 278.
`default_nettype none

module bcd_counter_temp_7seg_mux_unit
    import bcdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  show_temperature,
    input  wire logic [ADC_BITS-1:0]   adc_sample,
    // Output channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [7:0]            segment_byte,
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t cfg;
    cmd_t cmd;

    bcdc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    bcdc_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg              (cfg),
        .show_temperature (show_temperature),
        .adc_sample       (adc_sample),
        .segment_byte     (segment_byte)
    );

endmodule

`default_nettype wire

FILE: tb/bcdc_checker.sv
// Checker for the two-digit seven-segment counter with temperature display.
// Watches the item channels and register writes, predicts each segment byte
// and compares it. Depends on bcdc_pkg for widths and register indexes.
`default_nettype none

module bcdc_checker
    import bcdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic                  show_temperature,
    input  wire logic [ADC_BITS-1:0]   adc_sample,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [7:0]            segment_byte,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output int                         fail_count,
    output int                         outstanding,
    output int                         checked_count,
    output int                         temp_items,
    output int                         advances,
    output logic [LIMIT_W-1:0]         prescale_now
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] LAST_DIGIT = 4'd9;

    // Segment patterns for 0..9, own copy
    localparam logic [7:0] GLYPH [10] = '{
        8'hF3, 8'h60, 8'hB5, 8'hF4, 8'h66, 8'hD6, 8'hD7, 8'h70, 8'hF7, 8'hF6
    };

    // Shadow registers
    logic [LIMIT_W-1:0]  limit_q;
    logic [GAIN_W-1:0]   gain_q;
    logic [OFFSET_W-1:0] offset_q;

    // Counter state
    logic [LIMIT_W-1:0]  count_q;
    logic [3:0]          units_q;
    logic [3:0]          tens_q;
    logic                units_turn_q;

    logic [7:0]          segment_q [$];
    int                  mismatches;

    assign fail_count   = mismatches;
    assign prescale_now = count_q;

    function automatic logic [7:0] glyph(input logic [4:0] d);
        return (d > 5'd9) ? GLYPH[0] : GLYPH[d];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    // Predict on each accepted item, compare on each accepted result
    always @(posedge clk or negedge rst_n) begin : predict_and_check
        logic [19:0] product;
        logic [15:0] celsius_wide;
        logic [7:0]  celsius;
        logic [4:0]  show_units;
        logic [4:0]  show_tens;
        logic [7:0]  want;
        if (!rst_n) begin
            limit_q       = LIMIT_RESET;
            gain_q        = GAIN_RESET;
            offset_q      = OFFSET_RESET;
            count_q       = '0;
            units_q       = '0;
            tens_q        = '0;
            units_turn_q  = 1'b1;
            segment_q.delete();
            mismatches    = 0;
            outstanding   <= 0;
            checked_count <= 0;
            temp_items    <= 0;
            advances      <= 0;
        end
        else begin
            // Register writes land in the access cycle
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                case (reg_index_t'(paddr[3:2]))
                    REG_PRESCALE_LIMIT: limit_q  = pwdata[LIMIT_W-1:0];
                    REG_TEMP_GAIN:      gain_q   = pwdata[GAIN_W-1:0];
                    REG_TEMP_OFFSET:    offset_q = pwdata[OFFSET_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall) begin
                if (!show_temperature) begin
                    // counter mode: prescaler then decimal step
                    if (count_q == limit_q) begin
                        count_q  = '0;
                        advances <= advances + 1;
                        if (units_q >= LAST_DIGIT) begin
                            units_q = '0;
                            tens_q  = (tens_q >= LAST_DIGIT) ? 4'd0 : tens_q + 4'd1;
                        end
                        else begin
                            units_q = units_q + 4'd1;
                        end
                    end
                    else begin
                        count_q = count_q + 1'b1;
                    end
                    show_units = {1'b0, units_q};
                    show_tens  = {1'b0, tens_q};
                end
                else begin
                    // temperature: full-width product, /1024, minus offset, low byte
                    product      = adc_sample * gain_q;
                    celsius_wide = 16'(product >> 10) - 16'(offset_q);
                    celsius      = celsius_wide[7:0];
                    show_units   = 5'(celsius % 8'd10);
                    show_tens    = 5'(celsius / 8'd10);
                    temp_items   <= temp_items + 1;
                end
                if (units_turn_q)
                    want = glyph(show_units);
                else
                    want = glyph(show_tens) | TENS_SELECT;
                units_turn_q = !units_turn_q;
                segment_q.push_back(want);
            end

            if (out_valid && !out_stall) begin
                checked_count <= checked_count + 1;
                if (segment_q.size() == 0) begin
                    report_mismatch($sformatf("segment_byte %02h with no item outstanding",
                                              segment_byte));
                end
                else begin
                    want = segment_q.pop_front();
                    if (segment_byte !== want)
                        report_mismatch($sformatf("segment_byte %02h, expected %02h",
                                                  segment_byte, want));
                end
            end
            outstanding <= segment_q.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Testbench top for bcd_counter_temp_7seg_mux_unit: clock, reset, stimulus,
// register writes and the verdict. Depends on bcdc_pkg, the block and
// bcdc_checker, which does all prediction and comparison.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bcdc_pkg::*;

    localparam int         CLK_PERIOD      = 8;
    localparam int         RESET_CYCLES    = 11;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         NUM_PHASES      = 8;
    localparam int         PHASE_ITEMS     = 104;
    localparam int         TALL_PHASE      = 3;
    localparam int         PAST_PHASE      = 4;
    localparam logic [1:0] UNMAPPED_INDEX  = 2'd3;
    localparam logic [9:0] SAMPLE_MAX      = 10'd1023;

    logic                  clk              = 1'b0;
    logic                  rst_n            = 1'b0;
    logic                  in_valid         = 1'b0;
    logic                  in_stall;
    logic                  show_temperature = 1'b0;
    logic [ADC_BITS-1:0]   adc_sample       = '0;
    logic                  out_valid;
    logic                  out_stall        = 1'b0;
    logic [7:0]            segment_byte;
    logic                  psel             = 1'b0;
    logic                  penable          = 1'b0;
    logic                  pwrite           = 1'b0;
    logic [APB_ADDR_W-1:0] paddr            = '0;
    logic [APB_DATA_W-1:0] pwdata           = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    outstanding;
    int                    checked_count;
    int                    temp_items;
    int                    advances;
    logic [LIMIT_W-1:0]    prescale_now;

    int                    items_sent   = 0;
    int                    settings     = 0;
    int unsigned           cycle_count  = 0;
    logic                  calm         = 1'b0;
    int                    stall_left   = 0;

    bcd_counter_temp_7seg_mux_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .show_temperature (show_temperature),
        .adc_sample       (adc_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .segment_byte     (segment_byte),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    bcdc_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .show_temperature (show_temperature),
        .adc_sample       (adc_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .segment_byte     (segment_byte),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .checked_count    (checked_count),
        .temp_items       (temp_items),
        .advances         (advances),
        .prescale_now     (prescale_now)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        return (($urandom_range(0, 19) < 16) ? $urandom_range(1, 3)
                                             : $urandom_range(10, 40));
    endfunction

    // Receiver stalls in runs, none while calm
    always @(posedge clk) begin
        if (calm) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= idle_len() - 1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic temp, input logic [ADC_BITS-1:0] sample);
        show_temperature <= temp;
        adc_sample       <= sample;
        in_valid         <= 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
    endtask

    // Stop sending and let every outstanding result come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Register field with random upper bus bits
    function automatic logic [31:0] with_noise(input logic [31:0] field, input int width);
        logic [31:0] keep;
        keep = (32'h1 << width) - 1;
        return ($urandom() & ~keep) | (field & keep);
    endfunction

    function automatic logic [9:0] ten_bit_value();
        case ($urandom_range(0, 3))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [9:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 10'd0;
            1:       return SAMPLE_MAX;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    initial begin : stimulus
        int          temp_pct;
        logic [16:0] next_limit;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: temperature extremes and mid values, both digits
        send_item(1'b1, 10'd0);
        send_item(1'b1, 10'd0);
        send_item(1'b1, SAMPLE_MAX);
        send_item(1'b1, SAMPLE_MAX);
        send_item(1'b1, 10'd682);
        send_item(1'b1, 10'd512);
        drain();

        // Extreme gain, no offset, counter advancing every tick
        write_reg(REG_PRESCALE_LIMIT, with_noise(32'd0, LIMIT_W));
        write_reg(REG_TEMP_GAIN, with_noise(32'd1023, GAIN_W));
        write_reg(REG_TEMP_OFFSET, with_noise(32'd0, OFFSET_W));
        write_reg(UNMAPPED_INDEX, $urandom());
        settings++;
        send_item(1'b1, SAMPLE_MAX);
        send_item(1'b1, SAMPLE_MAX);
        send_item(1'b1, 10'd0);
        send_item(1'b1, 10'd0);
        repeat (6) send_item(1'b0, random_sample());
        drain();

        // No gain, largest offset: wraps below zero
        write_reg(REG_TEMP_GAIN, with_noise(32'd0, GAIN_W));
        write_reg(REG_TEMP_OFFSET, with_noise(32'd1023, OFFSET_W));
        settings++;
        send_item(1'b1, 10'h155);
        send_item(1'b1, 10'h2AA);
        send_item(1'b0, 10'h2AA);
        send_item(1'b0, 10'h155);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p <= 1)
                next_limit = 17'd0;
            else if (p == TALL_PHASE)
                next_limit = 17'hFFFF;
            else if (p == PAST_PHASE)
                next_limit = (prescale_now > 0) ? 17'(prescale_now) - 17'd1 : 17'd0;
            else
                next_limit = 17'(prescale_now) + 17'($urandom_range(0, 5));
            if (next_limit > 17'hFFFF)
                next_limit = 17'hFFFF;
            write_reg(REG_PRESCALE_LIMIT, with_noise(32'(next_limit), LIMIT_W));
            write_reg(REG_TEMP_GAIN, with_noise(32'(ten_bit_value()), GAIN_W));
            write_reg(REG_TEMP_OFFSET, with_noise(32'(ten_bit_value()), OFFSET_W));
            settings++;

            calm     = (p % 3 == 2);
            temp_pct = (p <= 1) ? 10 : $urandom_range(20, 70);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_item($urandom_range(0, 99) < temp_pct, random_sample());
                // hold off mid-phase until the block has emptied
                if (p == 2 && i == PHASE_ITEMS / 2)
                    drain();
            end
            drain();
        end
        calm = 1'b0;

        $display("Sent %0d items (%0d temperature), %0d counter advances, %0d results checked",
                 items_sent, temp_items, advances, checked_count);
        $display("Went through %0d register settings in %0d cycles", settings, cycle_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
